// ===== sv/gic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_pkg: shared types and constants
// Constants, command and status types for the gamepad input conditioner.
// ----------------------------------------------------------------------------
package gic_pkg;

    localparam logic [14:0] DZ_RESET   = 15'd7849;
    localparam logic [14:0] FS_RESET   = 15'd31128;
    localparam logic [15:0] UNIT_Q15   = 16'd32767;
    localparam logic [15:0] DIAG_Q15   = 16'd23170;
    localparam logic [7:0]  TRIG_MIN   = 8'd26;
    localparam logic        REG_DZ     = 1'b0;
    localparam logic        REG_FS     = 1'b1;

    // Controller commands to the datapath.
    typedef struct packed {
        logic load;       // capture a new item
        logic sq_start;   // start square root of the selected stick
        logic dv_start;   // start divide for the selected axis
        logic stick_sel;  // 0 left, 1 right
        logic axis_sel;   // 0 x, 1 y
        logic finish;     // form the result and update state
    } t_cmd;

    // Datapath status to the controller.
    typedef struct packed {
        logic sq_done;
        logic dv_done;
    } t_sts;

endpackage

// ===== sv/gic_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_datapath: conditioning datapath
// Holds the item, a shared bit-serial square root and a shared restoring
// divider, and forms the result and the frame-to-frame state.
// ----------------------------------------------------------------------------
module gic_datapath import gic_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [14:0]        i_dz,
    input  logic [14:0]        i_fs,
    input  logic               i_pad_present,
    input  logic signed [15:0] i_left_x,
    input  logic signed [15:0] i_left_y,
    input  logic signed [15:0] i_right_x,
    input  logic signed [15:0] i_right_y,
    input  logic [15:0]        i_button_bits,
    input  logic [7:0]         i_left_pull,
    input  logic [7:0]         i_right_pull,
    input  logic [3:0]         i_key_dirs,
    input  logic signed [15:0] i_pointer_x,
    input  logic signed [15:0] i_pointer_y,
    input  logic               i_pointer_ok,
    output logic signed [15:0] o_move_x,
    output logic signed [15:0] o_move_y,
    output logic signed [16:0] o_look_x,
    output logic signed [16:0] o_look_y,
    output logic               o_device_sel,
    output logic [15:0]        o_held_mask,
    output logic [15:0]        o_pressed_mask,
    output logic [15:0]        o_released_mask,
    output logic [7:0]         o_left_level,
    output logic [7:0]         o_right_level,
    output logic               o_pad_seen
);

    // Captured item (pad fields already masked).
    logic               r_pad;
    logic signed [15:0] r_lx, r_ly, r_rx, r_ry, r_px, r_py;
    logic [15:0]        r_btn;
    logic [7:0]         r_lt, r_rt;
    logic [3:0]         r_keys;
    logic               r_pok;

    // Frame-to-frame state.
    logic [15:0]        r_last_btn;
    logic signed [15:0] r_last_px, r_last_py;
    logic               r_pkn, r_dev;

    // Squared magnitudes of both sticks and the squared deadzone.
    logic [31:0] ml2, mr2;
    logic [31:0] r_dz2;

    // Per-stick magnitude and conditioned outputs.
    logic [23:0] r_mq;
    logic signed [15:0] r_lsx, r_lsy, r_rsx, r_rsy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pad  <= i_pad_present;
            r_lx   <= i_pad_present ? i_left_x  : 16'sd0;
            r_ly   <= i_pad_present ? i_left_y  : 16'sd0;
            r_rx   <= i_pad_present ? i_right_x : 16'sd0;
            r_ry   <= i_pad_present ? i_right_y : 16'sd0;
            r_btn  <= i_pad_present ? i_button_bits : 16'd0;
            r_lt   <= i_pad_present ? i_left_pull  : 8'd0;
            r_rt   <= i_pad_present ? i_right_pull : 8'd0;
            r_keys <= i_key_dirs;
            r_px   <= i_pointer_x;
            r_py   <= i_pointer_y;
            r_pok  <= i_pointer_ok;
        end
    end

    // Squares of the axes, one multiplier each, registered from the loaded item while r_sq_phase is set.
    logic r_sq_phase;
    logic signed [31:0] r_sqa, r_sqb, r_sqc, r_sqd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sq_phase <= 1'b0;
        else          r_sq_phase <= i_cmd.load;
        if (r_sq_phase) begin
            r_sqa <= r_lx * r_lx;
            r_sqb <= r_ly * r_ly;
            r_sqc <= r_rx * r_rx;
            r_sqd <= r_ry * r_ry;
            r_dz2 <= {17'd0, i_dz} * {17'd0, i_dz};
        end
    end
    assign ml2 = 32'(r_sqa) + 32'(r_sqb);
    assign mr2 = 32'(r_sqc) + 32'(r_sqd);

    // Square root of (m2 << 16): bit-serial, 24 result bits.
    logic [31:0] sel_m2;
    logic [47:0] r_rem_src;
    logic [25:0] r_sq_rem;
    logic [23:0] r_sq_root;
    logic [4:0]  r_sq_cnt;
    logic        r_sq_busy, r_sq_done;
    logic [25:0] sq_trial, sq_rem_sh;
    assign sel_m2    = i_cmd.stick_sel ? mr2 : ml2;
    assign sq_rem_sh = {r_sq_rem[23:0], r_rem_src[47:46]};
    assign sq_trial  = {r_sq_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
            r_sq_done <= 1'b0;
        end else begin
            r_sq_done <= 1'b0;
            if (i_cmd.sq_start) begin
                r_sq_busy <= 1'b1;
                r_sq_cnt  <= 5'd0;
            end else if (r_sq_busy) begin
                r_sq_cnt <= r_sq_cnt + 5'd1;
                if (r_sq_cnt == 5'd23) begin
                    r_sq_busy <= 1'b0;
                    r_sq_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_start) begin
            r_rem_src <= {sel_m2, 16'd0};
            r_sq_rem  <= 26'd0;
            r_sq_root <= 24'd0;
        end else if (r_sq_busy) begin
            r_rem_src <= {r_rem_src[45:0], 2'b00};
            if (sq_rem_sh >= sq_trial) begin
                r_sq_rem  <= sq_rem_sh - sq_trial;
                r_sq_root <= {r_sq_root[22:0], 1'b1};
            end else begin
                r_sq_rem  <= sq_rem_sh;
                r_sq_root <= {r_sq_root[22:0], 1'b0};
            end
        end
        if (r_sq_done) r_mq <= (r_sq_root == 24'd0) ? 24'd1 : r_sq_root;
    end

    // Numerator and denominator of the scale for the selected stick.
    logic        fs_le_dz, sat;
    logic [23:0] dz256, fs256;
    logic [15:0] span;
    logic [23:0] num_w;
    logic [39:0] den_w;
    assign fs_le_dz = (i_fs <= i_dz);
    assign dz256    = {1'b0, i_dz, 8'd0};
    assign fs256    = {1'b0, i_fs, 8'd0};
    assign sat      = fs_le_dz || (r_mq >= fs256);
    assign span     = 16'(i_fs) - 16'(i_dz);

    // Denominator product span*mq and numerator, registered at the start of the x divide and kept for y.
    logic [39:0] r_den;
    logic [23:0] r_num;
    always_ff @(posedge i_clk) begin
        if (r_sq_done) begin
            r_den <= 40'd0;
        end
        if (i_cmd.dv_start && !i_cmd.axis_sel) begin
            r_num <= num_w;
            r_den <= den_w;
        end
    end
    assign num_w = sat ? 24'd256 : ((r_mq > dz256) ? r_mq - dz256 : 24'd0);
    assign den_w = sat ? {16'd0, r_mq} : 40'(span) * 40'(r_mq);

    // Scaled product p = |c| * 32767 * num: two multiplies, |c| * 32767 registered in r_ac.
    logic signed [15:0] sel_c;
    logic [15:0]        abs_c;
    logic [31:0]        r_ac;
    logic               r_neg;
    logic [55:0]        p_w;
    assign sel_c = i_cmd.stick_sel ? (i_cmd.axis_sel ? r_ry : r_rx)
                                   : (i_cmd.axis_sel ? r_ly : r_lx);
    assign abs_c = sel_c[15] ? 16'(-sel_c) : 16'(sel_c);

    // Divide q = (2p + den) / (2den), restoring, one bit per cycle over 58 steps.
    // Only 18 quotient bits are kept with a sticky overflow flag, since the
    // result saturates at 32767.
    logic [40:0] r_dv_rem;
    logic [57:0] r_dv_n;
    logic [40:0] r_dv_d;
    logic [17:0] r_dv_q;
    logic [5:0]  r_dv_cnt;
    logic        r_dv_busy, r_dv_done, r_dv_pre, r_dv_big;
    logic [41:0] dv_sh;
    assign p_w   = 56'(r_ac) * 56'(r_num);
    assign dv_sh = {r_dv_rem, r_dv_n[57]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_done <= 1'b0;
            r_dv_pre  <= 1'b0;
        end else begin
            r_dv_done <= 1'b0;
            r_dv_pre  <= i_cmd.dv_start;
            if (r_dv_pre) begin
                r_dv_busy <= 1'b1;
                r_dv_cnt  <= 6'd0;
            end else if (r_dv_busy) begin
                r_dv_cnt <= r_dv_cnt + 6'd1;
                if (r_dv_cnt == 6'd57) begin
                    r_dv_busy <= 1'b0;
                    r_dv_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dv_start) begin
            r_ac  <= 32'(abs_c) * 32'(UNIT_Q15);
            r_neg <= sel_c[15];
        end
        if (r_dv_pre) begin
            r_dv_n   <= {1'b0, p_w, 1'b0} + 58'(i_cmd.dv_start ? 40'd0 : r_den);
            r_dv_d   <= {r_den, 1'b0};
            r_dv_rem <= 41'd0;
            r_dv_q   <= 18'd0;
            r_dv_big <= 1'b0;
        end else if (r_dv_busy) begin
            r_dv_n <= {r_dv_n[56:0], 1'b0};
            if (dv_sh >= {1'b0, r_dv_d}) begin
                r_dv_rem <= 41'(dv_sh - {1'b0, r_dv_d});
                r_dv_q   <= {r_dv_q[16:0], 1'b1};
                if (r_dv_q[17]) r_dv_big <= 1'b1;
            end else begin
                r_dv_rem <= 41'(dv_sh);
                r_dv_q   <= {r_dv_q[16:0], 1'b0};
                if (r_dv_q[17]) r_dv_big <= 1'b1;
            end
        end
    end

    // Saturate and sign the quotient (zero inside the deadzone), then store it in the stick output slot.
    logic r_dz_zero;
    logic [15:0] q_sat;
    logic signed [15:0] q_sgn;
    assign q_sat = (r_dv_big || r_dv_q > 18'(UNIT_Q15)) ? UNIT_Q15 : r_dv_q[15:0];
    assign q_sgn = r_neg ? -$signed(q_sat) : $signed(q_sat);
    logic r_st_sel, r_ax_sel;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_start) begin
            r_dz_zero <= (sel_m2 == 32'd0) || (sel_m2 <= r_dz2);
        end
        if (i_cmd.dv_start) begin
            r_st_sel <= i_cmd.stick_sel;
            r_ax_sel <= i_cmd.axis_sel;
        end
        if (r_dv_done) begin
            case ({r_st_sel, r_ax_sel})
                2'b00:   r_lsx <= r_dz_zero ? 16'sd0 : q_sgn;
                2'b01:   r_lsy <= r_dz_zero ? 16'sd0 : q_sgn;
                2'b10:   r_rsx <= r_dz_zero ? 16'sd0 : q_sgn;
                default: r_rsy <= r_dz_zero ? 16'sd0 : q_sgn;
            endcase
        end
    end

    assign o_sts.sq_done = r_sq_done;
    assign o_sts.dv_done = r_dv_done;

    // Keys, mouse delta, device choice and result register.
    logic signed [1:0]  kx, ky;
    logic               kb_act, ms_act, pad_act, dev_n;
    logic signed [15:0] kvx, kvy, kmag;
    logic signed [16:0] mx, my;
    assign kx     = $signed({1'b0, r_keys[0]}) - $signed({1'b0, r_keys[1]});
    assign ky     = $signed({1'b0, r_keys[2]}) - $signed({1'b0, r_keys[3]});
    assign kb_act = (kx != 2'sd0) || (ky != 2'sd0);
    assign kmag   = (kx != 2'sd0 && ky != 2'sd0) ? $signed(DIAG_Q15) : $signed(UNIT_Q15);
    assign kvx    = (kx == 2'sd0) ? 16'sd0 : (kx[1] ? -kmag : kmag);
    assign kvy    = (ky == 2'sd0) ? 16'sd0 : (ky[1] ? -kmag : kmag);
    assign mx     = (r_pok && r_pkn) ? 17'(r_px) - 17'(r_last_px) : 17'sd0;
    assign my     = (r_pok && r_pkn) ? 17'(r_py) - 17'(r_last_py) : 17'sd0;
    assign ms_act = (mx != 17'sd0) || (my != 17'sd0);
    assign pad_act = (r_btn != 16'd0) || (r_lt >= TRIG_MIN) || (r_rt >= TRIG_MIN)
                   || (ml2 > r_dz2) || (mr2 > r_dz2);
    assign dev_n  = pad_act ? 1'b0 : ((kb_act || ms_act) ? 1'b1 : r_dev);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_btn <= 16'd0;
            r_last_px  <= 16'sd0;
            r_last_py  <= 16'sd0;
            r_pkn      <= 1'b0;
            r_dev      <= 1'b0;
        end else if (i_cmd.finish) begin
            r_last_btn <= r_btn;
            r_dev      <= dev_n;
            if (r_pok) begin
                r_last_px <= r_px;
                r_last_py <= r_py;
                r_pkn     <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_move_x        <= dev_n ? kvx : r_lsx;
            o_move_y        <= dev_n ? kvy : r_lsy;
            o_look_x        <= dev_n ? mx  : 17'(r_rsx);
            o_look_y        <= dev_n ? my  : 17'(r_rsy);
            o_device_sel    <= dev_n;
            o_held_mask     <= r_btn;
            o_pressed_mask  <= (r_btn ^ r_last_btn) & r_btn;
            o_released_mask <= (r_btn ^ r_last_btn) & r_last_btn;
            o_left_level    <= r_lt;
            o_right_level   <= r_rt;
            o_pad_seen      <= r_pad;
        end
    end

endmodule

// ===== sv/gic_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gic_ctrl: sequencing controller
// Steps one item through load, per-stick square root, four divides and
// the result, and runs the input and output handshakes.
// ----------------------------------------------------------------------------
module gic_ctrl import gic_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQR  = 6'b000010,
        S_SQW  = 6'b000100,
        S_DIV  = 6'b001000,
        S_DVW  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_stick, n_stick, r_axis, n_axis, r_wait, n_wait;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_stick = r_stick;
        n_axis  = r_axis;
        n_wait  = 1'b0;
        o_cmd   = '0;
        o_cmd.stick_sel = r_stick;
        o_cmd.axis_sel  = r_axis;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_stick    = 1'b0;
                    n_axis     = 1'b0;
                    n_state    = S_SQR;
                end
            end
            S_SQR: begin
                // Wait for the squares to register, using r_wait.
                n_wait = 1'b1;
                if (r_wait) begin
                    o_cmd.sq_start = 1'b1;
                    n_state        = S_SQW;
                end
            end
            S_SQW: if (i_sts.sq_done) n_state = S_DIV;
            S_DIV: begin
                n_wait = 1'b1;
                if (r_wait || r_axis) begin
                    o_cmd.dv_start = 1'b1;
                    n_state        = S_DVW;
                end
            end
            S_DVW: begin
                if (i_sts.dv_done) begin
                    if (!r_axis) begin
                        n_axis  = 1'b1;
                        n_state = S_DIV;
                    end else if (!r_stick) begin
                        n_stick = 1'b1;
                        n_axis  = 1'b0;
                        n_state = S_SQR;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!o_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stick     <= 1'b0;
            r_axis      <= 1'b0;
            r_wait      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stick <= n_stick;
            r_axis  <= n_axis;
            r_wait  <= n_wait;
            if (o_cmd.finish)     o_out_valid <= 1'b1;
            else if (i_out_ready) o_out_valid <= 1'b0;
        end
    end

    // A result is only formed when the output register is free or draining.
    a_fin_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!o_out_valid || i_out_ready))
        else $error("result formed over a held result");
    // Only one unit starts at a time.
    a_one_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.sq_start && o_cmd.dv_start))
        else $error("square root and divide started together");
    // The result appears the cycle after finish.
    a_out_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> o_out_valid)
        else $error("finished item not presented");

endmodule

// ===== sv/gamepad_input_conditioner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_core: top level
// Conditions one frame sample of pad, keys and cursor into a unified result.
//
//   Channel   Handshake                Payload
//   in        i_in_valid / o_in_ready  pad, sticks, buttons, triggers, keys, cursor
//   out       o_out_valid / i_out_ready move, look, device, masks, levels
//   cfg       i_cfg_we                 i_cfg_index, i_cfg_data
//
// Per stick, an item passes through a setup wait, a 24-step square root and
// two divides of 58 steps each plus setup, all on one shared root unit and
// one shared divider. One item is in work at a time; a result waiting on the
// output stalls only the final step of the next item. Reset is synchronous
// and active low.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner_core import gic_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [14:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_pad_present,
    input  logic signed [15:0] i_left_x,
    input  logic signed [15:0] i_left_y,
    input  logic signed [15:0] i_right_x,
    input  logic signed [15:0] i_right_y,
    input  logic [15:0]        i_button_bits,
    input  logic [7:0]         i_left_pull,
    input  logic [7:0]         i_right_pull,
    input  logic [3:0]         i_key_dirs,
    input  logic signed [15:0] i_pointer_x,
    input  logic signed [15:0] i_pointer_y,
    input  logic               i_pointer_ok,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_move_x,
    output logic signed [15:0] o_move_y,
    output logic signed [16:0] o_look_x,
    output logic signed [16:0] o_look_y,
    output logic               o_device_sel,
    output logic [15:0]        o_held_mask,
    output logic [15:0]        o_pressed_mask,
    output logic [15:0]        o_released_mask,
    output logic [7:0]         o_left_level,
    output logic [7:0]         o_right_level,
    output logic               o_pad_seen
);

    logic [14:0] r_dz, r_fs;
    t_cmd cmd;
    t_sts sts;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz <= DZ_RESET;
            r_fs <= FS_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_DZ) r_dz <= i_cfg_data;
            if (i_cfg_index == REG_FS) r_fs <= i_cfg_data;
        end
    end

    gic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gic_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_dz            (r_dz),
        .i_fs            (r_fs),
        .i_pad_present   (i_pad_present),
        .i_left_x        (i_left_x),
        .i_left_y        (i_left_y),
        .i_right_x       (i_right_x),
        .i_right_y       (i_right_y),
        .i_button_bits   (i_button_bits),
        .i_left_pull     (i_left_pull),
        .i_right_pull    (i_right_pull),
        .i_key_dirs      (i_key_dirs),
        .i_pointer_x     (i_pointer_x),
        .i_pointer_y     (i_pointer_y),
        .i_pointer_ok    (i_pointer_ok),
        .o_move_x        (o_move_x),
        .o_move_y        (o_move_y),
        .o_look_x        (o_look_x),
        .o_look_y        (o_look_y),
        .o_device_sel    (o_device_sel),
        .o_held_mask     (o_held_mask),
        .o_pressed_mask  (o_pressed_mask),
        .o_released_mask (o_released_mask),
        .o_left_level    (o_left_level),
        .o_right_level   (o_right_level),
        .o_pad_seen      (o_pad_seen)
    );

endmodule
